[rtl/core/gap_pkg.sv]
package gap_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_PLAN  = 2'd1;
  localparam logic [1:0] REQ_POP   = 2'd2;

  localparam logic [15:0] COST_ORTHO = 16'd10;
  localparam logic [15:0] COST_DIAG  = 16'd14;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic       cell_blocked;
    logic [5:0] goal_x;
    logic [5:0] goal_y;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [11:0] path_len;
    logic        step_valid;
    logic [5:0]  step_x;
    logic [5:0]  step_y;
  } res_t;

  // per-cell search record
  typedef struct packed {
    logic        open_f;
    logic        closed_f;
    logic [2:0]  dir;
    logic [15:0] g;
    logic [16:0] f;
  } node_t;

  function automatic logic signed [1:0] dir_dx(logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd0, 3'd3, 3'd5: r = -2'sd1;
      3'd1, 3'd6:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dy(logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd0, 3'd1, 3'd2: r = -2'sd1;
      3'd3, 3'd4:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] step_cost(logic [2:0] d);
    logic [15:0] r;
    case (d)
      3'd0, 3'd2, 3'd5, 3'd7: r = COST_DIAG;
      default:                r = COST_ORTHO;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/gap_ram.sv]
module gap_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/gap_heur.sv]
module gap_heur (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [5:0] x_i,
  input  logic [5:0] y_i,
  input  logic [5:0] gx_i,
  input  logic [5:0] gy_i,
  output logic       done_o,
  output logic [9:0] h_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  logic [1:0]  stage_q, stage_d;
  logic [12:0] dsq_q, dsq_d;
  logic [19:0] v_q, v_d;
  logic [9:0]  r_q, r_d;
  logic [3:0]  bit_q, bit_d;
  logic        done_q, done_d;

  logic [5:0]  dx, dy;
  logic [11:0] sqx, sqy;
  logic [9:0]  trial;
  logic [19:0] tsq;

  always_comb begin
    dx = (x_i > gx_i) ? x_i - gx_i : gx_i - x_i;
    dy = (y_i > gy_i) ? y_i - gy_i : gy_i - y_i;
    sqx = dx * dx;
    sqy = dy * dy;
    trial = r_q | (10'd1 << bit_q);
    tsq = trial * trial;

    stage_d = stage_q;
    dsq_d = dsq_q;
    v_d = v_q;
    r_d = r_q;
    bit_d = bit_q;
    done_d = 1'b0;
    case (stage_q)
      ST_IDLE: begin
        if (start_i) begin
          dsq_d = {1'b0, sqx} + {1'b0, sqy};
          stage_d = ST_MUL;
        end
      end
      ST_MUL: begin
        v_d = 20'(dsq_q) * 20'd100;
        r_d = '0;
        bit_d = 4'd9;
        stage_d = ST_ROOT;
      end
      ST_ROOT: begin
        // one result bit per cycle, msb first
        if (tsq <= v_q) begin
          r_d = trial;
        end
        if (bit_q == 4'd0) begin
          done_d = 1'b1;
          stage_d = ST_IDLE;
        end else begin
          bit_d = bit_q - 4'd1;
        end
      end
      default: stage_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      stage_q <= stage_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsq_q <= dsq_d;
    v_q <= v_d;
    r_q <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign h_o = r_q;

endmodule

[rtl/core/grid_astar_path_planner_unit.sv]
// write request: wall cell written when taken, then S_DONE; pop request: S_POPRD, then S_DONE
// plan request: a clearing pass over the node memory, then per expansion a scan of the
// width*height cells through the node memory read port, S_SCANEND to close the cell and up
// to 8 neighbor updates (each with a heuristic square root); path store through S_PATH and
// S_PATHD for each step; one request at a time; a new request is taken while a result waits
// for the consumer
// reset: async active low; the wall map is swept passable after reset
module grid_astar_path_planner_unit
  import gap_pkg::*;
#(
  parameter int GRID_DIM = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_wdata_i
);

  localparam int DimUse = (GRID_DIM < 64) ? GRID_DIM : 64;
  localparam int CW = $clog2(DimUse);
  localparam int AW = 2 * CW;
  localparam int Depth = 2 ** AW;
  localparam int PCW = AW + 1;
  localparam int NW = $bits(node_t);

  localparam logic [3:0] S_CLRW   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLRN   = 4'd2;
  localparam logic [3:0] S_SINIT  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SCANEND = 4'd5;
  localparam logic [3:0] S_NBR    = 4'd6;
  localparam logic [3:0] S_NBRD   = 4'd7;
  localparam logic [3:0] S_HEUR   = 4'd8;
  localparam logic [3:0] S_PATH   = 4'd9;
  localparam logic [3:0] S_PATHD  = 4'd10;
  localparam logic [3:0] S_POPRD  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  function automatic logic [AW-1:0] addr_of(logic [5:0] x, logic [5:0] y);
    return {y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic logic [6:0] clamp_dim(logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'(DimUse)) r = 7'(DimUse);
    else r = v;
    return r;
  endfunction

  function automatic logic [11:0] to_len(logic [PCW-1:0] v);
    logic [12:0] t;
    t = 13'(v);
    return t[11:0];
  endfunction

  logic [3:0]     state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [6:0]     wcfg_q, hcfg_q;
  logic [6:0]     w_q, w_d, h_q, h_d;
  logic [5:0]     sx_q, sx_d, sy_q, sy_d, gx_q, gx_d, gy_q, gy_d;
  logic [5:0]     scx_q, scx_d, scy_q, scy_d;
  logic           iss_done_q, iss_done_d;
  logic           rd_v_q, rd_v_d;
  logic [5:0]     rd_x_q, rd_x_d, rd_y_q, rd_y_d;
  logic           any_q, any_d;
  node_t          best_q, best_d;
  logic [5:0]     bx_q, bx_d, by_q, by_d;
  logic [2:0]     dir_q, dir_d;
  logic [5:0]     nx_q, nx_d, ny_q, ny_d;
  logic [15:0]    ng_q, ng_d;
  logic [5:0]     curx_q, curx_d, cury_q, cury_d;
  logic [PCW-1:0] pcnt_q, pcnt_d, pptr_q, pptr_d;
  res_t           res_q, res_d;
  logic           out_valid_q, out_valid_d;
  res_t           out_q;
  logic           load_out;

  logic           wall_we, wall_wdata, wall_rdata;
  logic [AW-1:0]  wall_waddr, wall_raddr;
  logic           node_we;
  logic [AW-1:0]  node_waddr, node_raddr;
  node_t          node_wdata, node_rdata;
  logic [NW-1:0]  node_rbits;
  logic           path_we;
  logic [AW-1:0]  path_waddr, path_raddr;
  logic [11:0]    path_wdata, path_rdata;

  logic           hu_start, hu_done;
  logic [5:0]     hu_x, hu_y;
  logic [9:0]     hu_h;

  logic           nbr_next, start_scan;
  logic signed [7:0] nxs, nys;
  logic [15:0]    gnew;
  logic [6:0]     wc, hc;
  logic [PCW-1:0] pidx;

  gap_ram #(.Width(1), .Depth(Depth)) u_wall (
    .clk_i,
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  gap_ram #(.Width(NW), .Depth(Depth)) u_node (
    .clk_i,
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rbits)
  );
  assign node_rdata = node_rbits;

  gap_ram #(.Width(12), .Depth(Depth)) u_path (
    .clk_i,
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .raddr_i (path_raddr),
    .rdata_o (path_rdata)
  );

  gap_heur u_heur (
    .clk_i,
    .rst_ni,
    .start_i (hu_start),
    .x_i     (hu_x),
    .y_i     (hu_y),
    .gx_i    (gx_q),
    .gy_i    (gy_q),
    .done_o  (hu_done),
    .h_o     (hu_h)
  );

  assign hu_x = (state_q == S_CLRN) ? sx_q : nx_q;
  assign hu_y = (state_q == S_CLRN) ? sy_q : ny_q;

  always_comb begin
    nxs = $signed({2'b00, bx_q}) + 8'(dir_dx(dir_q));
    nys = $signed({2'b00, by_q}) + 8'(dir_dy(dir_q));
    gnew = best_q.g + step_cost(dir_q);
    wc = clamp_dim(wcfg_q);
    hc = clamp_dim(hcfg_q);

    state_d = state_q;
    clr_d = clr_q;
    w_d = w_q;
    h_d = h_q;
    sx_d = sx_q;
    sy_d = sy_q;
    gx_d = gx_q;
    gy_d = gy_q;
    scx_d = scx_q;
    scy_d = scy_q;
    iss_done_d = iss_done_q;
    rd_v_d = 1'b0;
    rd_x_d = rd_x_q;
    rd_y_d = rd_y_q;
    any_d = any_q;
    best_d = best_q;
    bx_d = bx_q;
    by_d = by_q;
    dir_d = dir_q;
    nx_d = nx_q;
    ny_d = ny_q;
    ng_d = ng_q;
    curx_d = curx_q;
    cury_d = cury_q;
    pcnt_d = pcnt_q;
    pptr_d = pptr_q;
    res_d = res_q;
    load_out = 1'b0;
    in_ready_o = 1'b0;

    wall_we = 1'b0;
    wall_waddr = clr_q;
    wall_wdata = 1'b0;
    wall_raddr = addr_of(nxs[5:0], nys[5:0]);
    node_we = 1'b0;
    node_waddr = clr_q;
    node_wdata = '0;
    node_raddr = addr_of(scx_q, scy_q);
    path_we = 1'b0;
    path_waddr = pcnt_q[AW-1:0];
    path_wdata = {cury_q, curx_q};
    pidx = pcnt_q - pptr_q - PCW'(1);
    path_raddr = pidx[AW-1:0];
    hu_start = 1'b0;
    nbr_next = 1'b0;
    start_scan = 1'b0;

    case (state_q)
      S_CLRW: begin
        wall_we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          state_d = S_DONE;
          case (in_req_i.req_type)
            REQ_WRITE: begin
              if ({1'b0, in_req_i.pos_x} < 7'(DimUse) &&
                  {1'b0, in_req_i.pos_y} < 7'(DimUse)) begin
                wall_we = 1'b1;
                wall_waddr = addr_of(in_req_i.pos_x, in_req_i.pos_y);
                wall_wdata = in_req_i.cell_blocked;
              end
            end
            REQ_PLAN: begin
              pcnt_d = '0;
              pptr_d = '0;
              w_d = wc;
              h_d = hc;
              sx_d = in_req_i.pos_x;
              sy_d = in_req_i.pos_y;
              gx_d = in_req_i.goal_x;
              gy_d = in_req_i.goal_y;
              if ({1'b0, in_req_i.pos_x} >= wc || {1'b0, in_req_i.pos_y} >= hc ||
                  {1'b0, in_req_i.goal_x} >= wc || {1'b0, in_req_i.goal_y} >= hc) begin
                res_d.found = 1'b0;
              end else if (in_req_i.pos_x == in_req_i.goal_x &&
                           in_req_i.pos_y == in_req_i.goal_y) begin
                res_d.found = 1'b1;
              end else begin
                clr_d = '0;
                state_d = S_CLRN;
              end
            end
            REQ_POP: begin
              if (pptr_q < pcnt_q) begin
                pptr_d = pptr_q + PCW'(1);
                state_d = S_POPRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLRN: begin
        node_we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          hu_start = 1'b1;
          state_d = S_SINIT;
        end
      end
      S_SINIT: begin
        if (hu_done) begin
          node_we = 1'b1;
          node_waddr = addr_of(sx_q, sy_q);
          node_wdata = '{open_f: 1'b1, closed_f: 1'b0, dir: 3'd0, g: 16'd0,
                         f: 17'(hu_h)};
          start_scan = 1'b1;
        end
      end
      S_SCAN: begin
        if (!iss_done_q) begin
          rd_v_d = 1'b1;
          rd_x_d = scx_q;
          rd_y_d = scy_q;
          if ({1'b0, scx_q} == w_q - 7'd1) begin
            scx_d = '0;
            scy_d = scy_q + 6'd1;
            if ({1'b0, scy_q} == h_q - 7'd1) begin
              iss_done_d = 1'b1;
            end
          end else begin
            scx_d = scx_q + 6'd1;
          end
        end
        // strict compare keeps the lowest cell index on ties
        if (rd_v_q && node_rdata.open_f && (!any_q || node_rdata.f < best_q.f)) begin
          any_d = 1'b1;
          best_d = node_rdata;
          bx_d = rd_x_q;
          by_d = rd_y_q;
        end
        if (iss_done_q && !rd_v_q) begin
          state_d = S_SCANEND;
        end
      end
      S_SCANEND: begin
        if (!any_q) begin
          res_d.found = 1'b0;
          state_d = S_DONE;
        end else begin
          node_we = 1'b1;
          node_waddr = addr_of(bx_q, by_q);
          node_wdata = best_q;
          node_wdata.open_f = 1'b0;
          node_wdata.closed_f = 1'b1;
          if (bx_q == gx_q && by_q == gy_q) begin
            curx_d = gx_q;
            cury_d = gy_q;
            state_d = S_PATH;
          end else begin
            dir_d = 3'd0;
            state_d = S_NBR;
          end
        end
      end
      S_NBR: begin
        if (nxs[7] || nys[7] || nxs >= $signed({1'b0, w_q}) ||
            nys >= $signed({1'b0, h_q})) begin
          nbr_next = 1'b1;
        end else begin
          node_raddr = addr_of(nxs[5:0], nys[5:0]);
          nx_d = nxs[5:0];
          ny_d = nys[5:0];
          state_d = S_NBRD;
        end
      end
      S_NBRD: begin
        if (!wall_rdata && !node_rdata.closed_f &&
            (!node_rdata.open_f || gnew < node_rdata.g)) begin
          ng_d = gnew;
          hu_start = 1'b1;
          state_d = S_HEUR;
        end else begin
          nbr_next = 1'b1;
        end
      end
      S_HEUR: begin
        if (hu_done) begin
          node_we = 1'b1;
          node_waddr = addr_of(nx_q, ny_q);
          node_wdata = '{open_f: 1'b1, closed_f: 1'b0, dir: dir_q, g: ng_q,
                         f: 17'(ng_q) + 17'(hu_h)};
          nbr_next = 1'b1;
        end
      end
      S_PATH: begin
        // path is stored goal first and popped from the far end
        if (curx_q == sx_q && cury_q == sy_q) begin
          res_d.found = 1'b1;
          res_d.path_len = to_len(pcnt_q);
          state_d = S_DONE;
        end else begin
          node_raddr = addr_of(curx_q, cury_q);
          path_we = 1'b1;
          pcnt_d = pcnt_q + PCW'(1);
          state_d = S_PATHD;
        end
      end
      S_PATHD: begin
        curx_d = curx_q - 6'(dir_dx(node_rdata.dir));
        cury_d = cury_q - 6'(dir_dy(node_rdata.dir));
        state_d = S_PATH;
      end
      S_POPRD: begin
        res_d.step_valid = 1'b1;
        res_d.step_x = path_rdata[5:0];
        res_d.step_y = path_rdata[11:6];
        res_d.path_len = to_len(pcnt_q - pptr_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (nbr_next) begin
      if (dir_q == 3'd7) begin
        start_scan = 1'b1;
      end else begin
        dir_d = dir_q + 3'd1;
        state_d = S_NBR;
      end
    end
    if (start_scan) begin
      scx_d = '0;
      scy_d = '0;
      iss_done_d = 1'b0;
      any_d = 1'b0;
      state_d = S_SCAN;
    end
  end

  always_comb begin
    if (load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLRW;
      clr_q <= '0;
      wcfg_q <= 7'd64;
      hcfg_q <= 7'd64;
      pcnt_q <= '0;
      pptr_q <= '0;
      out_valid_q <= 1'b0;
      rd_v_q <= 1'b0;
      iss_done_q <= 1'b0;
      any_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (cfg_we_i && !cfg_idx_i) wcfg_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i) hcfg_q <= cfg_wdata_i;
      pcnt_q <= pcnt_d;
      pptr_q <= pptr_d;
      out_valid_q <= out_valid_d;
      rd_v_q <= rd_v_d;
      iss_done_q <= iss_done_d;
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    h_q <= h_d;
    sx_q <= sx_d;
    sy_q <= sy_d;
    gx_q <= gx_d;
    gy_q <= gy_d;
    scx_q <= scx_d;
    scy_q <= scy_d;
    rd_x_q <= rd_x_d;
    rd_y_q <= rd_y_d;
    best_q <= best_d;
    bx_q <= bx_d;
    by_q <= by_d;
    dir_q <= dir_d;
    nx_q <= nx_d;
    ny_q <= ny_d;
    ng_q <= ng_d;
    curx_q <= curx_d;
    cury_q <= cury_d;
    res_q <= res_d;
    if (load_out) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o = out_q;

`ifndef SYNTHESIS
  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pptr_q <= pcnt_q) else $error("pop pointer beyond stored path");

  a_heur_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hu_done |-> (state_q == S_SINIT || state_q == S_HEUR))
    else $error("heuristic finished outside a waiting state");

  a_close_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCANEND && any_q) |-> best_q.open_f)
    else $error("expanding a cell that is not open");
`endif

endmodule

[tb/tb.sv]
module tb;
  import gap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 64;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  class planner_scoreboard;
    int unsigned cols = 64;
    int unsigned rows = 64;
    bit          wall[DIM*DIM];
    int unsigned g_cost[DIM*DIM];
    int unsigned f_est[DIM*DIM];
    bit [2:0]    back_dir[DIM*DIM];
    bit          is_open[DIM*DIM];
    bit          is_closed[DIM*DIM];
    bit [11:0]   route[DIM*DIM];
    int unsigned route_len;
    int unsigned route_ptr;
    int          step_dx[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int          step_dy[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    res_t        expected_q[$];
    int unsigned mismatches;

    function int unsigned clamp(int unsigned v);
      if (v < 1) return 1;
      if (v > DIM) return DIM;
      return v;
    endfunction

    function int unsigned dist_est(int x, int y, int gx, int gy);
      int unsigned dx, dy, v, r;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      v = 100 * (dx * dx + dy * dy);
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    function bit search(int sx, int sy, int gx, int gy);
      int unsigned w, h, bf, c, n, g;
      int bx, by, nx, ny, x, y;
      bit any;
      w = clamp(cols);
      h = clamp(rows);
      route_len = 0;
      route_ptr = 0;
      if (sx >= w || sy >= h || gx >= w || gy >= h) return 0;
      if (sx == gx && sy == gy) return 1;
      foreach (is_open[i]) begin
        is_open[i] = 0;
        is_closed[i] = 0;
      end
      c = sy * DIM + sx;
      is_open[c] = 1;
      g_cost[c] = 0;
      f_est[c] = dist_est(sx, sy, gx, gy);
      back_dir[c] = 0;
      forever begin
        any = 0;
        bf = 0;
        bx = 0;
        by = 0;
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++) begin
            c = y * DIM + x;
            if (is_open[c] && (!any || f_est[c] < bf)) begin
              any = 1;
              bf = f_est[c];
              bx = x;
              by = y;
            end
          end
        if (!any) return 0;
        c = by * DIM + bx;
        is_open[c] = 0;
        is_closed[c] = 1;
        if (bx == gx && by == gy) begin
          // walk back from the goal, then fill the route back to front
          x = gx;
          y = gy;
          while (x != sx || y != sy) begin
            n = y * DIM + x;
            x -= step_dx[back_dir[n]];
            y -= step_dy[back_dir[n]];
            route_len++;
          end
          x = gx;
          y = gy;
          for (int k = route_len - 1; k >= 0; k--) begin
            n = y * DIM + x;
            route[k] = {y[5:0], x[5:0]};
            x -= step_dx[back_dir[n]];
            y -= step_dy[back_dir[n]];
          end
          return 1;
        end
        for (int d = 0; d < 8; d++) begin
          nx = bx + step_dx[d];
          ny = by + step_dy[d];
          if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
          n = ny * DIM + nx;
          if (wall[n] || is_closed[n]) continue;
          g = g_cost[c] + ((step_dx[d] != 0 && step_dy[d] != 0) ? 14 : 10);
          if (!is_open[n] || g < g_cost[n]) begin
            is_open[n] = 1;
            g_cost[n] = g;
            f_est[n] = g + dist_est(nx, ny, gx, gy);
            back_dir[n] = d[2:0];
          end
        end
      end
    endfunction

    function void note_request(req_t r);
      res_t e;
      e = '0;
      case (r.req_type)
        REQ_WRITE: wall[r.pos_y * DIM + r.pos_x] = r.cell_blocked;
        REQ_PLAN: begin
          e.found = search(r.pos_x, r.pos_y, r.goal_x, r.goal_y);
          e.path_len = route_len[11:0];
        end
        REQ_POP: begin
          if (route_ptr < route_len) begin
            e.step_valid = 1'b1;
            e.step_x = route[route_ptr][5:0];
            e.step_y = route[route_ptr][11:6];
            route_ptr++;
            e.path_len = 12'(route_len - route_ptr);
          end
        end
        default: ;
      endcase
      expected_q.push_back(e);
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d len=%0d sv=%0d x=%0d y=%0d",
                   a.found, a.path_len, a.step_valid, a.step_x, a.step_y);
        return;
      end
      e = expected_q.pop_front();
      if (a.found !== e.found || a.path_len !== e.path_len ||
          a.step_valid !== e.step_valid || a.step_x !== e.step_x ||
          a.step_y !== e.step_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp found=%0d len=%0d sv=%0d x=%0d y=%0d | got %0d %0d %0d %0d %0d",
                   e.found, e.path_len, e.step_valid, e.step_x, e.step_y,
                   a.found, a.path_len, a.step_valid, a.step_x, a.step_y);
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  req_t       in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  res_t       out_res_o;
  logic       cfg_we_i = 0;
  logic       cfg_idx_i = 0;
  logic [6:0] cfg_wdata_i = '0;

  planner_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;

  grid_astar_path_planner_unit #(.GRID_DIM(DIM)) dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_res_o);

  task automatic send(req_t r);
    bit idle;
    do begin
      @(negedge clk_i);
      idle = ($urandom_range(99) < send_idle_pct);
      in_valid_i = !idle;
    end while (idle);
    in_req_i = r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, logic [6:0] v);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 0;
    if (idx == CFG_WIDTH) sb.cols = v;
    else sb.rows = v;
  endtask

  function automatic req_t mk(logic [1:0] t, int px, int py, bit b, int gx, int gy);
    req_t r;
    r.req_type = t;
    r.pos_x = px[5:0];
    r.pos_y = py[5:0];
    r.cell_blocked = b;
    r.goal_x = gx[5:0];
    r.goal_y = gy[5:0];
    return r;
  endfunction

  function automatic req_t rand_req();
    int unsigned w, h, k, mx, my;
    req_t r;
    w = sb.clamp(sb.cols);
    h = sb.clamp(sb.rows);
    mx = (w + 1 > 63) ? 63 : w + 1;
    my = (h + 1 > 63) ? 63 : h + 1;
    r = $bits(req_t)'($urandom);
    k = $urandom_range(99);
    if (k < 40) begin
      r.req_type = REQ_WRITE;
      r.pos_x = 6'($urandom_range(mx));
      r.pos_y = 6'($urandom_range(my));
      r.cell_blocked = ($urandom_range(99) < 30);
    end else if (k < 62) begin
      r.req_type = REQ_PLAN;
      if ($urandom_range(9) == 0) begin
        r.pos_x = 6'($urandom_range(mx));
        r.goal_y = 6'($urandom_range(my));
      end else begin
        r.pos_x = 6'($urandom_range(w - 1));
        r.pos_y = 6'($urandom_range(h - 1));
        r.goal_x = 6'($urandom_range(w - 1));
        r.goal_y = 6'($urandom_range(h - 1));
      end
    end else if (k < 96) begin
      r.req_type = REQ_POP;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  int unsigned ph_w[4] = '{8, 64, 1, 5};
  int unsigned ph_h[4] = '{8, 1, 64, 7};
  int unsigned ph_send[4] = '{0, 80, 0, 16};
  int unsigned ph_recv[4] = '{0, 0, 80, 16};

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // full 64x64 grid
    send(mk(REQ_WRITE, 0, 0, 1, 63, 63));
    send(mk(REQ_WRITE, 63, 63, 1, 0, 0));
    send(mk(REQ_PLAN, 0, 0, 0, 3, 2));
    repeat (4) send(mk(REQ_POP, 0, 0, 0, 0, 0));
    send(mk(REQ_PLAN, 5, 5, 1, 5, 5));
    send(mk(REQ_POP, 63, 63, 1, 63, 63));
    send(mk(REQ_UNUSED, 63, 63, 1, 63, 63));
    // wall in the start so the goal cannot be reached
    send(mk(REQ_WRITE, 1, 0, 1, 0, 0));
    send(mk(REQ_WRITE, 0, 1, 1, 0, 0));
    send(mk(REQ_WRITE, 1, 1, 1, 0, 0));
    send(mk(REQ_PLAN, 0, 0, 0, 0, 2));
    send(mk(REQ_PLAN, 63, 63, 0, 60, 62));
    send(mk(REQ_POP, 0, 0, 0, 0, 0));
    drain();

    // out-of-range register values saturate
    set_reg(CFG_WIDTH, 7'd0);
    set_reg(CFG_HEIGHT, 7'd127);
    send(mk(REQ_PLAN, 0, 0, 0, 1, 0));
    send(mk(REQ_PLAN, 0, 4, 0, 0, 1));
    repeat (4) send(mk(REQ_POP, 0, 0, 0, 0, 0));
    drain();
    set_reg(CFG_WIDTH, 7'd127);
    set_reg(CFG_HEIGHT, 7'd0);
    send(mk(REQ_PLAN, 0, 0, 0, 0, 1));
    send(mk(REQ_PLAN, 62, 0, 0, 59, 0));
    drain();

    for (int p = 0; p < 4; p++) begin
      set_reg(CFG_WIDTH, ph_w[p][6:0]);
      set_reg(CFG_HEIGHT, ph_h[p][6:0]);
      send_idle_pct = ph_send[p];
      recv_stall_pct = ph_recv[p];
      for (int i = 0; i < 25; i++) send(rand_req());
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gap_pkg.sv
rtl/core/gap_ram.sv
rtl/core/gap_heur.sv
rtl/core/grid_astar_path_planner_unit.sv
tb/tb.sv
